>>> rtl/segregated_fit_heap_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sfha_pkg.sv
package sfha_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int BIN_COUNT  = 256;
  localparam int WORD_COUNT = HEAP_BYTES / 4;
  localparam int HAW        = $clog2(WORD_COUNT);
  localparam int BAW        = $clog2(BIN_COUNT);
  localparam int DW         = 18;
  localparam int HEW        = 17;
  localparam int CW         = 17;
  localparam int WALK_LIMIT = HEAP_BYTES / 16;
  localparam int NW         = $clog2(WALK_LIMIT) + 1;

  localparam logic [CW-1:0]  CHUNK_RESET    = 17'd4096;
  localparam logic [HEW-1:0] HEAP_END_RESET = 17'd4112;
  localparam logic [HEW-1:0] HEAP_LIMIT     = HEW'(HEAP_BYTES);
  localparam logic [DW-1:0]  MIN_BLOCK      = 18'd16;
  localparam logic [DW-1:0]  TAG_MASK       = ~18'd7;
  localparam logic [DW-1:0]  INIT_BIN_HEAD  = 18'd16;

  // Reset image of the tag memory: prologue, one free chunk, epilogue.
  localparam logic [HAW-1:0] PRO_HDR_IDX  = HAW'(1);
  localparam logic [HAW-1:0] PRO_FTR_IDX  = HAW'(2);
  localparam logic [HAW-1:0] CHK_HDR_IDX  = HAW'(3);
  localparam logic [HAW-1:0] CHK_FTR_IDX  = HAW'(1026);
  localparam logic [HAW-1:0] EPI_HDR_IDX  = HAW'(1027);
  localparam logic [DW-1:0]  PRO_TAG      = 18'd9;
  localparam logic [DW-1:0]  CHK_TAG      = 18'd4096;
  localparam logic [DW-1:0]  EPI_TAG      = 18'd1;

  typedef struct packed {
    logic           hwe;
    logic [HAW-1:0] haddr;
    logic [DW-1:0]  hwdata;
    logic           bwe;
    logic [BAW-1:0] baddr;
    logic [DW-1:0]  bwdata;
  } mem_req_t;

  function automatic logic [DW-1:0] init_word(input logic [HAW-1:0] idx);
    logic [DW-1:0] v;
    v = '0;
    if (idx == PRO_HDR_IDX || idx == PRO_FTR_IDX) v = PRO_TAG;
    if (idx == CHK_HDR_IDX || idx == CHK_FTR_IDX) v = CHK_TAG;
    if (idx == EPI_HDR_IDX) v = EPI_TAG;
    return v;
  endfunction

  function automatic logic [BAW-1:0] bin_of(input logic [DW-1:0] size);
    logic [DW-4:0] b;
    b = size[DW-1:3];
    return (b >= (DW-3)'(BIN_COUNT)) ? '0 : b[BAW-1:0];
  endfunction

  function automatic logic [HAW-1:0] word_of(input logic [DW-1:0] a);
    return a[HAW+1:2];
  endfunction

endpackage

>>> rtl/sfha_ram.sv
module sfha_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sfha_ctrl.sv
module sfha_ctrl import sfha_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_kind,
  input  logic [15:0]     in_request_bytes,
  input  logic [15:0]     in_release_address,
  input  logic [CW-1:0]   chunk,
  input  logic [DW-1:0]   hrdata,
  input  logic [DW-1:0]   brdata,
  output mem_req_t        mreq,
  output logic            out_valid,
  output logic [15:0]     out_payload_address,
  output logic            out_success
);

  typedef enum logic [5:0] {
    S_IDLE, S_A_START, S_BS_RD, S_BS_CK, S_WK_RD0, S_WK_P, S_WK_SZ, S_WK_NX,
    S_G_CHK, S_G_EPI, S_G_MERGE, S_PL_0, S_PL_1, S_PL_2, S_PL_3, S_PL_4,
    S_FIN_ALLOC, S_F_START, S_F_HDR, S_F_LINK, S_F_MERGE, S_FIN_FREE,
    S_ST_0, S_ST_1, S_LK_0, S_LK_1, S_LK_2, S_LK_3, S_LK_4, S_LK_5,
    S_UL_SZ, S_UL_0, S_UL_1, S_UL_2, S_UL_3,
    S_MG_0, S_MG_1, S_MG_2, S_MG_3, S_MG_PBPRE, S_MG_BP, S_MG_PBPOST, S_MG_NB,
    S_MG_S0, S_MG_S1, S_MG_S2, S_MG_TAG, S_MG_LINK
  } state_t;

  state_t state_r, state_nxt, ret_l_r, ret_l_nxt, ret_m_r, ret_m_nxt;
  logic [15:0]    req_r, req_nxt, rel_r, rel_nxt;
  logic [16:0]    asize_r, asize_nxt;
  logic [DW-1:0]  bp_r, bp_nxt, size_r, size_nxt, nb_r, nb_nxt, pb_r, pb_nxt;
  logic           pa_r, pa_nxt, na_r, na_nxt;
  logic [DW-1:0]  la_bp_r, la_bp_nxt, la_size_r, la_size_nxt;
  logic           la_alloc_r, la_alloc_nxt, ul_rdsz_r, ul_rdsz_nxt;
  logic [DW-1:0]  head_r, head_nxt, nxt_r, nxt_nxt, prv_r, prv_nxt;
  logic [DW-1:0]  csize_r, csize_nxt, p_r, p_nxt;
  logic [BAW-1:0] lk_bin_r, lk_bin_nxt, b_r, b_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic [HEW-1:0] heap_end_r, heap_end_nxt;
  logic           out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic [15:0]    out_addr_r, out_addr_nxt;

  logic [16:0]    ext;
  logic [15:0]    q;
  logic [DW-1:0]  gb, sz, tgt;
  logic [HEW-1:0] room;

  always_comb begin
    state_nxt = state_r; ret_l_nxt = ret_l_r; ret_m_nxt = ret_m_r;
    req_nxt = req_r; rel_nxt = rel_r; asize_nxt = asize_r;
    bp_nxt = bp_r; size_nxt = size_r; nb_nxt = nb_r; pb_nxt = pb_r;
    pa_nxt = pa_r; na_nxt = na_r;
    la_bp_nxt = la_bp_r; la_size_nxt = la_size_r; la_alloc_nxt = la_alloc_r;
    ul_rdsz_nxt = ul_rdsz_r;
    head_nxt = head_r; nxt_nxt = nxt_r; prv_nxt = prv_r; csize_nxt = csize_r;
    p_nxt = p_r; lk_bin_nxt = lk_bin_r; b_nxt = b_r; n_nxt = n_r;
    heap_end_nxt = heap_end_r;
    out_valid_nxt = 1'b0; out_ok_nxt = out_ok_r; out_addr_nxt = out_addr_r;
    mreq = '0;
    ext = (asize_r > chunk) ? asize_r : chunk;
    q = 16'(ext >> 2) + 16'd1;
    gb = {q[15:1], 3'b000};
    room = HEAP_LIMIT - heap_end_r;
    sz = hrdata & TAG_MASK;
    tgt = pa_r ? bp_r : pb_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_request_bytes;
          rel_nxt = in_release_address;
          asize_nxt = (in_request_bytes <= 16'd8) ? 17'd16 :
                      ((17'(in_request_bytes) + 17'd15) & ~17'd7);
          state_nxt = in_kind ? S_F_START : S_A_START;
        end
      end
      S_A_START: begin
        if (req_r == '0) begin
          out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else if ((asize_r >> 3) < 17'(BIN_COUNT)) begin
          b_nxt = asize_r[BAW+2:3];
          state_nxt = S_BS_RD;
        end else begin
          state_nxt = S_WK_RD0;
        end
      end
      S_BS_RD: begin
        mreq.baddr = b_r;
        state_nxt = S_BS_CK;
      end
      S_BS_CK: begin
        if (brdata != '0) begin
          bp_nxt = brdata;
          state_nxt = S_PL_0;
        end else if (b_r == '1) begin
          state_nxt = S_WK_RD0;
        end else begin
          b_nxt = b_r + 1'b1;
          state_nxt = S_BS_RD;
        end
      end
      S_WK_RD0: begin
        mreq.baddr = '0;
        n_nxt = '0;
        state_nxt = S_WK_P;
      end
      S_WK_P: begin
        if (brdata == '0) begin
          state_nxt = S_G_CHK;
        end else begin
          p_nxt = brdata;
          mreq.haddr = word_of(brdata - DW'(4));
          state_nxt = S_WK_SZ;
        end
      end
      S_WK_SZ: begin
        if (sz >= DW'(asize_r)) begin
          bp_nxt = p_r;
          state_nxt = S_PL_0;
        end else begin
          mreq.haddr = word_of(p_r);
          n_nxt = n_r + 1'b1;
          state_nxt = S_WK_NX;
        end
      end
      S_WK_NX: begin
        if (n_r == NW'(WALK_LIMIT) || hrdata == '0) begin
          state_nxt = S_G_CHK;
        end else begin
          p_nxt = hrdata;
          mreq.haddr = word_of(hrdata - DW'(4));
          state_nxt = S_WK_SZ;
        end
      end
      S_G_CHK: begin
        if (gb > DW'(room)) begin
          out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          bp_nxt = DW'(heap_end_r);
          size_nxt = gb;
          la_bp_nxt = DW'(heap_end_r); la_size_nxt = gb; la_alloc_nxt = 1'b0;
          ret_l_nxt = S_G_EPI;
          state_nxt = S_ST_0;
        end
      end
      S_G_EPI: begin
        // new epilogue header, then link the grown block
        mreq.hwe = 1'b1;
        mreq.haddr = word_of(bp_r + size_r - DW'(4));
        mreq.hwdata = DW'(1);
        heap_end_nxt = heap_end_r + size_r[HEW-1:0];
        la_bp_nxt = bp_r;
        ret_l_nxt = S_G_MERGE;
        state_nxt = S_LK_0;
      end
      S_G_MERGE: begin
        ret_m_nxt = S_PL_0;
        state_nxt = S_MG_0;
      end
      S_PL_0: begin
        mreq.haddr = word_of(bp_r - DW'(4));
        state_nxt = S_PL_1;
      end
      S_PL_1: begin
        csize_nxt = sz;
        la_bp_nxt = bp_r; la_size_nxt = sz; ul_rdsz_nxt = 1'b0;
        ret_l_nxt = S_PL_2;
        state_nxt = S_UL_0;
      end
      S_PL_2: begin
        la_bp_nxt = bp_r; la_alloc_nxt = 1'b1;
        state_nxt = S_ST_0;
        if (csize_r >= DW'(asize_r) && (csize_r - DW'(asize_r)) >= MIN_BLOCK) begin
          la_size_nxt = DW'(asize_r);
          ret_l_nxt = S_PL_3;
        end else begin
          la_size_nxt = csize_r;
          ret_l_nxt = S_FIN_ALLOC;
        end
      end
      S_PL_3: begin
        la_bp_nxt = bp_r + DW'(asize_r);
        la_size_nxt = csize_r - DW'(asize_r);
        la_alloc_nxt = 1'b0;
        ret_l_nxt = S_PL_4;
        state_nxt = S_ST_0;
      end
      S_PL_4: begin
        la_bp_nxt = bp_r + DW'(asize_r);
        ret_l_nxt = S_FIN_ALLOC;
        state_nxt = S_LK_0;
      end
      S_FIN_ALLOC: begin
        out_valid_nxt = 1'b1; out_addr_nxt = bp_r[15:0]; out_ok_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_F_START: begin
        if (rel_r == '0) begin
          out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (rel_r[2:0] != 3'b000 || rel_r < 16'd16 ||
                     HEW'(rel_r) >= heap_end_r) begin
          out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          mreq.haddr = word_of(DW'(rel_r) - DW'(4));
          state_nxt = S_F_HDR;
        end
      end
      S_F_HDR: begin
        if (!hrdata[0] || sz < MIN_BLOCK ||
            sz > DW'(heap_end_r - HEW'(rel_r))) begin
          out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          bp_nxt = DW'(rel_r);
          la_bp_nxt = DW'(rel_r); la_size_nxt = sz; la_alloc_nxt = 1'b0;
          ret_l_nxt = S_F_LINK;
          state_nxt = S_ST_0;
        end
      end
      S_F_LINK: begin
        la_bp_nxt = bp_r;
        ret_l_nxt = S_F_MERGE;
        state_nxt = S_LK_0;
      end
      S_F_MERGE: begin
        ret_m_nxt = S_FIN_FREE;
        state_nxt = S_MG_0;
      end
      S_FIN_FREE: begin
        out_valid_nxt = 1'b1; out_addr_nxt = '0; out_ok_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      // header then footer
      S_ST_0: begin
        mreq.hwe = 1'b1;
        mreq.haddr = word_of(la_bp_r - DW'(4));
        mreq.hwdata = la_size_r | DW'(la_alloc_r);
        state_nxt = S_ST_1;
      end
      S_ST_1: begin
        mreq.hwe = 1'b1;
        mreq.haddr = word_of(la_bp_r + la_size_r - DW'(8));
        mreq.hwdata = la_size_r | DW'(la_alloc_r);
        state_nxt = ret_l_r;
      end
      // push at the head of its bin
      S_LK_0: begin
        mreq.haddr = word_of(la_bp_r - DW'(4));
        state_nxt = S_LK_1;
      end
      S_LK_1: begin
        lk_bin_nxt = bin_of(sz);
        mreq.baddr = bin_of(sz);
        state_nxt = S_LK_2;
      end
      S_LK_2: begin
        head_nxt = brdata;
        mreq.hwe = 1'b1;
        mreq.haddr = word_of(la_bp_r);
        mreq.hwdata = brdata;
        state_nxt = S_LK_3;
      end
      S_LK_3: begin
        mreq.hwe = 1'b1;
        mreq.haddr = word_of(la_bp_r + DW'(4));
        mreq.hwdata = '0;
        state_nxt = S_LK_4;
      end
      S_LK_4: begin
        if (head_r != '0) begin
          mreq.hwe = 1'b1;
          mreq.haddr = word_of(head_r + DW'(4));
          mreq.hwdata = la_bp_r;
        end
        state_nxt = S_LK_5;
      end
      S_LK_5: begin
        mreq.bwe = 1'b1;
        mreq.baddr = lk_bin_r;
        mreq.bwdata = la_bp_r;
        state_nxt = ret_l_r;
      end
      // unlink, optionally fetching the size first
      S_UL_SZ: begin
        mreq.haddr = word_of(la_bp_r - DW'(4));
        state_nxt = S_UL_0;
      end
      S_UL_0: begin
        if (ul_rdsz_r) begin
          la_size_nxt = sz;
        end
        mreq.haddr = word_of(la_bp_r);
        state_nxt = S_UL_1;
      end
      S_UL_1: begin
        nxt_nxt = hrdata;
        mreq.haddr = word_of(la_bp_r + DW'(4));
        state_nxt = S_UL_2;
      end
      S_UL_2: begin
        prv_nxt = hrdata;
        if (hrdata == '0) begin
          mreq.bwe = 1'b1;
          mreq.baddr = bin_of(la_size_r);
          mreq.bwdata = nxt_r;
        end else begin
          mreq.hwe = 1'b1;
          mreq.haddr = word_of(hrdata);
          mreq.hwdata = nxt_r;
        end
        state_nxt = S_UL_3;
      end
      S_UL_3: begin
        if (nxt_r != '0) begin
          mreq.hwe = 1'b1;
          mreq.haddr = word_of(nxt_r + DW'(4));
          mreq.hwdata = prv_r;
        end
        state_nxt = ret_l_r;
      end
      // coalesce with free neighbours
      S_MG_0: begin
        mreq.haddr = word_of(bp_r - DW'(4));
        state_nxt = S_MG_1;
      end
      S_MG_1: begin
        size_nxt = sz;
        nb_nxt = bp_r + sz;
        mreq.haddr = word_of(bp_r - DW'(8));
        state_nxt = S_MG_2;
      end
      S_MG_2: begin
        pa_nxt = hrdata[0];
        pb_nxt = bp_r - sz;
        mreq.haddr = word_of(nb_r - DW'(4));
        state_nxt = S_MG_3;
      end
      S_MG_3: begin
        na_nxt = hrdata[0];
        if (pa_r && hrdata[0]) begin
          state_nxt = ret_m_r;
        end else if (!pa_r && !hrdata[0]) begin
          state_nxt = S_MG_PBPRE;
        end else begin
          state_nxt = S_MG_BP;
        end
      end
      S_MG_PBPRE: begin
        la_bp_nxt = pb_r; ul_rdsz_nxt = 1'b1;
        ret_l_nxt = S_MG_BP;
        state_nxt = S_UL_SZ;
      end
      S_MG_BP: begin
        la_bp_nxt = bp_r; la_size_nxt = size_r; ul_rdsz_nxt = 1'b0;
        ret_l_nxt = na_r ? S_MG_PBPOST : S_MG_NB;
        state_nxt = S_UL_0;
      end
      S_MG_PBPOST: begin
        la_bp_nxt = pb_r; ul_rdsz_nxt = 1'b1;
        ret_l_nxt = S_MG_S0;
        state_nxt = S_UL_SZ;
      end
      S_MG_NB: begin
        la_bp_nxt = nb_r; ul_rdsz_nxt = 1'b1;
        ret_l_nxt = S_MG_S0;
        state_nxt = S_UL_SZ;
      end
      S_MG_S0: begin
        mreq.haddr = word_of(pb_r - DW'(4));
        state_nxt = S_MG_S1;
      end
      S_MG_S1: begin
        if (!pa_r) begin
          size_nxt = size_r + sz;
        end
        mreq.haddr = word_of(nb_r - DW'(4));
        state_nxt = S_MG_S2;
      end
      S_MG_S2: begin
        if (!na_r) begin
          size_nxt = size_r + sz;
        end
        state_nxt = S_MG_TAG;
      end
      S_MG_TAG: begin
        bp_nxt = tgt;
        la_bp_nxt = tgt; la_size_nxt = size_r; la_alloc_nxt = 1'b0;
        ret_l_nxt = S_MG_LINK;
        state_nxt = S_ST_0;
      end
      S_MG_LINK: begin
        la_bp_nxt = bp_r;
        ret_l_nxt = ret_m_r;
        state_nxt = S_LK_0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_l_r     <= S_IDLE;
      ret_m_r     <= S_IDLE;
      heap_end_r  <= HEAP_END_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_l_r     <= ret_l_nxt;
      ret_m_r     <= ret_m_nxt;
      heap_end_r  <= heap_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt; rel_r <= rel_nxt; asize_r <= asize_nxt;
    bp_r <= bp_nxt; size_r <= size_nxt; nb_r <= nb_nxt; pb_r <= pb_nxt;
    pa_r <= pa_nxt; na_r <= na_nxt;
    la_bp_r <= la_bp_nxt; la_size_r <= la_size_nxt; la_alloc_r <= la_alloc_nxt;
    ul_rdsz_r <= ul_rdsz_nxt;
    head_r <= head_nxt; nxt_r <= nxt_nxt; prv_r <= prv_nxt; csize_r <= csize_nxt;
    p_r <= p_nxt; lk_bin_r <= lk_bin_nxt; b_r <= b_nxt; n_r <= n_nxt;
    out_ok_r <= out_ok_nxt; out_addr_r <= out_addr_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_success         = out_ok_r;

endmodule

>>> rtl/segregated_fit_heap_allocator_core.sv
// Channel   Ports                                               Handshake
// request   in_kind, in_request_bytes, in_release_address       start & !busy
// result    out_payload_address, out_success                    out_valid, one cycle
// config    cfg_wdata (growth chunk bytes)                      cfg_we
//
// One request is in work at a time; busy stays high until its result beat.
// A zero allocate or null free is answered without touching memory, a bad free after its
// header check at most; an exact-bin hit unlinks and retags the block, a free merges with its
// free neighbours, a grow adds new tags. The bin scan reads empty bins one by one, the walk each link.
// After reset a clearing pass over all 16384 tag words loads the tag memory and bin heads;
// busy is high throughout. The result beat cannot be held off by the receiver.
`include "segregated_fit_heap_allocator_core_assert.svh"

module segregated_fit_heap_allocator_core import sfha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_kind,
  input  logic [15:0]   in_request_bytes,
  input  logic [15:0]   in_release_address,
  output logic          out_valid,
  output logic [15:0]   out_payload_address,
  output logic          out_success,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  logic [CW-1:0]  chunk_r;
  logic           clr_r;
  logic [HAW-1:0] clr_idx_r;
  logic           ctrl_busy;
  mem_req_t       ctrl_req;
  mem_req_t       mreq;
  logic [DW-1:0]  hrdata, brdata;

  // Hold the growth chunk register; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= CHUNK_RESET;
    end else if (cfg_we) begin
      chunk_r <= cfg_wdata;
    end
  end

  // Sweep every tag word once after reset; bin heads ride along on the low indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == '1) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Steer the memory ports: the sweep owns them until it is done.
  always_comb begin
    mreq = ctrl_req;
    if (clr_r) begin
      mreq.hwe    = 1'b1;
      mreq.haddr  = clr_idx_r;
      mreq.hwdata = init_word(clr_idx_r);
      mreq.bwe    = (clr_idx_r < HAW'(BIN_COUNT));
      mreq.baddr  = clr_idx_r[BAW-1:0];
      mreq.bwdata = (clr_idx_r == '0) ? INIT_BIN_HEAD : '0;
    end
  end

  sfha_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start & ~clr_r),
    .busy                (ctrl_busy),
    .in_kind             (in_kind),
    .in_request_bytes    (in_request_bytes),
    .in_release_address  (in_release_address),
    .chunk               (chunk_r),
    .hrdata              (hrdata),
    .brdata              (brdata),
    .mreq                (ctrl_req),
    .out_valid           (out_valid),
    .out_payload_address (out_payload_address),
    .out_success         (out_success)
  );

  // Tags, footers and free-list links.
  sfha_ram #(.ADDR_W(HAW), .DATA_W(DW)) u_heap (
    .clk   (clk),
    .we    (mreq.hwe),
    .addr  (mreq.haddr),
    .wdata (mreq.hwdata),
    .rdata (hrdata)
  );

  // Size-bin list heads.
  sfha_ram #(.ADDR_W(BAW), .DATA_W(DW)) u_bins (
    .clk   (clk),
    .we    (mreq.bwe),
    .addr  (mreq.baddr),
    .wdata (mreq.bwdata),
    .rdata (brdata)
  );

  assign busy = clr_r | ctrl_busy;

  `SFHA_ASSERT_NXT(a_accept_holds, start && !busy, busy, "accepted beat did not raise busy")
  `SFHA_ASSERT_IMP(a_result_idle, out_valid, !busy, "result beat while still busy")
  `SFHA_ASSERT_IMP(a_addr_success, out_valid && (out_payload_address != '0), out_success,
                   "nonzero address on a failed result")
  `SFHA_ASSERT_IMP(a_sweep_quiet, clr_r, !out_valid && !ctrl_busy, "activity during sweep")

endmodule
